/* rtl/vrs_pkg.sv */
// Shared types and constants of the rope step unit.
// Used by every module of the project but vrs_ram; depends on nothing.
package vrs_pkg;

   localparam int SEGMENTS   = 16;
   localparam int NODE_COUNT = SEGMENTS + 1;
   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int INDEX_W    = 6;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGLEN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PASSES  = 2'd3;

   localparam logic [30:0] GRAVITY_RST = 31'd39321600;
   localparam logic [15:0] DAMPING_RST = 16'd64225;
   localparam logic [30:0] SEGLEN_RST  = 31'd524288;
   localparam logic [3:0]  PASSES_RST  = 4'd4;

   localparam logic CMD_STEP = 1'b1;

   // squared length below 0.0001 px
   localparam logic [63:0] SHORT_SQ = 64'd43;

   // last step counts of the iterative units
   localparam logic [4:0] SQRT_LAST = 5'd31;
   localparam logic [5:0] MD_LAST   = 6'd38;

   typedef enum logic [1:0] {
      WS_INIT  = 2'd0,
      WS_ANCH  = 2'd1,
      WS_INTEG = 2'd2,
      WS_A     = 2'd3
   } vrs_wsrc_type;

   typedef struct packed {
      logic               capture;
      logic               grav_sq;
      logic               grav_mul;
      logic               acc_step;
      logic [NODE_W-1:0]  node;
      logic [NODE_W-1:0]  raddr;
      logic [NODE_W-1:0]  waddr;
      logic               we_pos;
      logic               we_prev;
      vrs_wsrc_type       wsrc;
      logic               int_mul;
      logic               load_a;
      logic               load_b;
      logic               shift_a;
      logic               sq_x;
      logic               sq_y;
      logic               sqrt_start;
      logic               err_calc;
      logic               first_seg;
      logic               md_start;
      logic               md_y;
      logic               take_c;
      logic               upd;
      logic               em_load;
   } vrs_cmd_type;

   typedef struct packed {
      logic       is_step;
      logic       skip;
      logic       sqrt_done;
      logic       md_done;
      logic [3:0] passes;
   } vrs_stat_type;

endpackage

/* rtl/vrs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module vrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/vrs_isqrt.sv */
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on vrs_pkg.
module vrs_isqrt
   import vrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;

   logic [35:0] rem2;
   logic [35:0] trial;
   logic [35:0] diff;
   logic        ge;

   assign rem2  = {rem_ff, rad_ff[63:62]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign ge    = rem2 >= trial;
   assign diff  = rem2 - trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[33:0] : rem2[33:0];
         root_in = {root_ff[30:0], ge};
         rad_in  = {rad_ff[61:0], 2'b00};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == SQRT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* rtl/vrs_muldiv.sv */
// Sequential floor(a*b/d): two 33x17 partial products, then 36 restoring
// division steps. Depends on vrs_pkg.
module vrs_muldiv
   import vrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] mcand,
   input  logic [33:0] mplier,
   input  logic [33:0] divisor,
   output logic        done,
   output logic [35:0] quot
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] a_ff, a_in;
   logic [33:0] b_ff, b_in;
   logic [33:0] d_ff, d_in;
   logic [66:0] prod_ff, prod_in;
   logic [34:0] rem_ff, rem_in;
   logic [35:0] q_ff, q_in;

   logic [16:0] mpart;
   logic [49:0] mo;
   logic [35:0] rem2;
   logic [35:0] diff;
   logic        ge;

   assign mpart = (cnt_ff == 6'd0) ? b_ff[33:17] : b_ff[16:0];
   assign mo    = a_ff * mpart;
   assign rem2  = {rem_ff, q_ff[35]};
   assign ge    = rem2 >= {2'b00, d_ff};
   assign diff  = rem2 - {2'b00, d_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      d_in    = d_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = mcand;
         b_in    = mplier;
         d_in    = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd0) begin
            prod_in = {17'b0, mo};
         end else if (cnt_ff == 6'd1) begin
            prod_in = {prod_ff[49:0], 17'b0} + {17'b0, mo};
         end else if (cnt_ff == 6'd2) begin
            // quotient fits 36 bits, so the upper part is already below d
            rem_in = {4'b0, prod_ff[66:36]};
            q_in   = prod_ff[35:0];
         end else begin
            rem_in = ge ? diff[34:0] : rem2[34:0];
            q_in   = {q_ff[34:0], ge};
            if (cnt_ff == MD_LAST) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      d_ff    <= d_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

/* rtl/vrs_datapath.sv */
// Datapath: config registers, node RAMs, integration, segment relaxation
// arithmetic and output register. Depends on vrs_pkg, vrs_ram, vrs_isqrt, vrs_muldiv.
module vrs_datapath
   import vrs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  vrs_cmd_type          cmd,
   output vrs_stat_type         stat,
   input  logic                 req_command,
   input  logic [31:0]          req_pivot_x,
   input  logic [31:0]          req_pivot_y,
   input  logic [15:0]          req_time_step,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output logic [INDEX_W-1:0]   rsp_node_index,
   output logic [31:0]          rsp_node_x,
   output logic [31:0]          rsp_node_y,
   output logic                 rsp_last_node
);

   function automatic logic [31:0] sat32(input logic signed [39:0] v);
      if (v > 40'sd2147483647) begin
         return 32'h7fffffff;
      end else if (v < -40'sd2147483648) begin
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   // config
   logic [30:0] grav_ff;
   logic [15:0] damp_ff;
   logic [30:0] seglen_ff;
   logic [3:0]  passes_ff;

   // command beat
   logic [31:0]        anc_x_ff, anc_y_ff;
   logic               cmd_ff;
   logic [15:0]        ts_ff;
   logic signed [39:0] acc_ff;
   logic [31:0]        tsq_ff;
   logic [30:0]        g_ff;

   // node storage
   logic [63:0]           pos_wd, prev_wd, pos_rdata, prev_rdata;
   logic [NODE_COUNT-1:0] valid_ff;
   logic                  rd_ok_ff;
   logic [31:0]           pos_rx, pos_ry, prev_rx, prev_ry;

   // integration
   logic signed [32:0] diff_x, diff_y;
   logic signed [49:0] prod_x_ff, prod_y_ff;
   logic signed [49:0] rnd_x, rnd_y;
   logic [31:0]        px_ff, py_ff;
   logic [31:0]        nx, ny;

   // relaxation
   logic [31:0]        ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic [32:0]        abs_x, abs_y;
   logic               half;
   logic [31:0]        sq_op;
   logic [63:0]        sqo;
   logic [63:0]        sq_ff;
   logic               sqrt_done;
   logic [31:0]        root;
   logic [32:0]        seg_dist;
   logic signed [34:0] err_ff;
   logic [33:0]        div_ff;
   logic [33:0]        abs_err;
   logic               md_done;
   logic [35:0]        quot;
   logic               c_neg;
   logic signed [36:0] c_val;
   logic signed [36:0] cx_ff, cy_ff;

   logic [62:0] gprod;
   logic [63:0] gsum;

   // output register
   logic [INDEX_W-1:0] rsp_idx_ff;
   logic [31:0]        rsp_x_ff, rsp_y_ff;
   logic               rsp_last_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff   <= GRAVITY_RST;
         damp_ff   <= DAMPING_RST;
         seglen_ff <= SEGLEN_RST;
         passes_ff <= PASSES_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRAVITY: grav_ff   <= csr_wdata[30:0];
            CSR_DAMPING: damp_ff   <= csr_wdata[15:0];
            CSR_SEGLEN:  seglen_ff <= csr_wdata[30:0];
            CSR_PASSES:  passes_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // gravity term: (g * dt^2 + half) >> 32
   assign gprod = grav_ff * tsq_ff;
   assign gsum  = {1'b0, gprod} + 64'h0000_0000_8000_0000;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         anc_x_ff <= req_pivot_x;
         anc_y_ff <= req_pivot_y;
         cmd_ff   <= req_command;
         ts_ff    <= req_time_step;
         acc_ff   <= {{8{req_pivot_y[31]}}, req_pivot_y};
      end else if (cmd.acc_step) begin
         acc_ff <= acc_ff + {9'b0, seglen_ff};
      end
      if (cmd.grav_sq) begin
         tsq_ff <= ts_ff * ts_ff;
      end
      if (cmd.grav_mul) begin
         g_ff <= gsum[62:32];
      end
   end

   // node RAMs, {y, x}; entries never written read as zero
   always_comb begin
      case (cmd.wsrc)
         WS_INIT: begin
            pos_wd  = {sat32(acc_ff), anc_x_ff};
            prev_wd = pos_wd;
         end
         WS_ANCH: begin
            pos_wd  = {anc_y_ff, anc_x_ff};
            prev_wd = pos_wd;
         end
         WS_INTEG: begin
            pos_wd  = {ny, nx};
            prev_wd = {py_ff, px_ff};
         end
         WS_A: begin
            pos_wd  = {ay_ff, ax_ff};
            prev_wd = pos_wd;
         end
         default: begin
            pos_wd  = {ay_ff, ax_ff};
            prev_wd = pos_wd;
         end
      endcase
   end

   vrs_ram #(.WIDTH(64), .DEPTH(NODE_COUNT)) u_pos_ram (
      .clock (clock),
      .we    (cmd.we_pos),
      .waddr (cmd.waddr),
      .wdata (pos_wd),
      .raddr (cmd.raddr),
      .rdata (pos_rdata)
   );

   vrs_ram #(.WIDTH(64), .DEPTH(NODE_COUNT)) u_prev_ram (
      .clock (clock),
      .we    (cmd.we_prev),
      .waddr (cmd.waddr),
      .wdata (prev_wd),
      .raddr (cmd.raddr),
      .rdata (prev_rdata)
   );

   // pos and prev are always written together before any pos-only write
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.we_prev) begin
         valid_ff[cmd.waddr] <= 1'b1;
      end
      rd_ok_ff <= valid_ff[cmd.raddr];
   end

   assign pos_rx  = rd_ok_ff ? pos_rdata[31:0]   : 32'd0;
   assign pos_ry  = rd_ok_ff ? pos_rdata[63:32]  : 32'd0;
   assign prev_rx = rd_ok_ff ? prev_rdata[31:0]  : 32'd0;
   assign prev_ry = rd_ok_ff ? prev_rdata[63:32] : 32'd0;

   // damped Verlet
   assign diff_x = $signed({pos_rx[31], pos_rx}) - $signed({prev_rx[31], prev_rx});
   assign diff_y = $signed({pos_ry[31], pos_ry}) - $signed({prev_ry[31], prev_ry});
   assign rnd_x  = prod_x_ff + 50'sd32768;
   assign rnd_y  = prod_y_ff + 50'sd32768;

   always_comb begin
      logic signed [39:0] sx, sy;
      sx = $signed({{8{px_ff[31]}}, px_ff}) + $signed({{6{rnd_x[49]}}, rnd_x[49:16]});
      sy = $signed({{8{py_ff[31]}}, py_ff}) + $signed({{6{rnd_y[49]}}, rnd_y[49:16]})
         + $signed({9'b0, g_ff});
      nx = sat32(sx);
      ny = sat32(sy);
   end

   always_ff @(posedge clock) begin
      if (cmd.int_mul) begin
         prod_x_ff <= diff_x * $signed({1'b0, damp_ff});
         prod_y_ff <= diff_y * $signed({1'b0, damp_ff});
         px_ff     <= pos_rx;
         py_ff     <= pos_ry;
      end
   end

   // segment geometry
   assign abs_x = dx_ff[32] ? 33'(-dx_ff) : dx_ff;
   assign abs_y = dy_ff[32] ? 33'(-dy_ff) : dy_ff;
   assign half  = abs_x[32] | abs_x[31] | abs_y[32] | abs_y[31];
   always_comb begin
      if (cmd.sq_y) begin
         sq_op = half ? abs_y[32:1] : abs_y[31:0];
      end else begin
         sq_op = half ? abs_x[32:1] : abs_x[31:0];
      end
   end
   assign sqo = sq_op * sq_op;

   vrs_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (sq_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   assign seg_dist = half ? {root, 1'b0} : {1'b0, root};
   assign abs_err  = err_ff[34] ? 34'(-err_ff) : err_ff[33:0];

   vrs_muldiv u_muldiv (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.md_start),
      .mcand   (cmd.md_y ? abs_y : abs_x),
      .mplier  (abs_err),
      .divisor (div_ff),
      .done    (md_done),
      .quot    (quot)
   );

   assign c_neg = (cmd.md_y ? dy_ff[32] : dx_ff[32]) ^ err_ff[34];
   assign c_val = c_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

   always_ff @(posedge clock) begin
      if (cmd.load_a) begin
         ax_ff <= pos_rx;
         ay_ff <= pos_ry;
      end else if (cmd.shift_a) begin
         ax_ff <= bx_ff;
         ay_ff <= by_ff;
      end else if (cmd.upd && !cmd.first_seg) begin
         ax_ff <= sat32($signed({{8{ax_ff[31]}}, ax_ff}) + $signed({{3{cx_ff[36]}}, cx_ff}));
         ay_ff <= sat32($signed({{8{ay_ff[31]}}, ay_ff}) + $signed({{3{cy_ff[36]}}, cy_ff}));
      end
      if (cmd.load_b) begin
         bx_ff <= pos_rx;
         by_ff <= pos_ry;
         dx_ff <= $signed({pos_rx[31], pos_rx}) - $signed({ax_ff[31], ax_ff});
         dy_ff <= $signed({pos_ry[31], pos_ry}) - $signed({ay_ff[31], ay_ff});
      end else if (cmd.upd) begin
         bx_ff <= sat32($signed({{8{bx_ff[31]}}, bx_ff}) - $signed({{3{cx_ff[36]}}, cx_ff}));
         by_ff <= sat32($signed({{8{by_ff[31]}}, by_ff}) - $signed({{3{cy_ff[36]}}, cy_ff}));
      end
      if (cmd.sq_x) begin
         sq_ff <= sqo;
      end else if (cmd.sq_y) begin
         sq_ff <= sq_ff + sqo;
      end
      if (cmd.err_calc) begin
         err_ff <= $signed({2'b00, seg_dist}) - $signed({4'b0000, seglen_ff});
         div_ff <= cmd.first_seg ? {1'b0, seg_dist} : {seg_dist, 1'b0};
      end
      if (cmd.take_c) begin
         if (cmd.md_y) begin
            cy_ff <= c_val;
         end else begin
            cx_ff <= c_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.em_load) begin
         rsp_idx_ff  <= INDEX_W'(cmd.node);
         rsp_x_ff    <= pos_rx;
         rsp_y_ff    <= pos_ry;
         rsp_last_ff <= cmd.node == NODE_W'(SEGMENTS);
      end
   end

   assign rsp_node_index = rsp_idx_ff;
   assign rsp_node_x     = rsp_x_ff;
   assign rsp_node_y     = rsp_y_ff;
   assign rsp_last_node  = rsp_last_ff;

   assign stat.is_step   = cmd_ff == CMD_STEP;
   assign stat.skip      = !half && (sq_ff < SHORT_SQ);
   assign stat.sqrt_done = sqrt_done;
   assign stat.md_done   = md_done;
   assign stat.passes    = passes_ff;

endmodule

/* rtl/vrs_ctrl.sv */
// Sequencer of the rope step unit: node and pass counters, handshakes.
// Depends on vrs_pkg.
module vrs_ctrl
   import vrs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  vrs_stat_type stat,
   output vrs_cmd_type  cmd
);

   typedef enum logic [27:0] {
      ST_IDLE     = 28'h0000001,
      ST_DISPATCH = 28'h0000002,
      ST_INIT_WR  = 28'h0000004,
      ST_GRAV_SQ  = 28'h0000008,
      ST_GRAV_MUL = 28'h0000010,
      ST_INT_ANCH = 28'h0000020,
      ST_INT_RD   = 28'h0000040,
      ST_INT_MUL  = 28'h0000080,
      ST_INT_WR   = 28'h0000100,
      ST_RLX_RDA  = 28'h0000200,
      ST_RLX_LDA  = 28'h0000400,
      ST_RLX_RDB  = 28'h0000800,
      ST_RLX_LDB  = 28'h0001000,
      ST_RLX_SQX  = 28'h0002000,
      ST_RLX_SQY  = 28'h0004000,
      ST_RLX_SQS  = 28'h0008000,
      ST_RLX_SQW  = 28'h0010000,
      ST_RLX_ERR  = 28'h0020000,
      ST_RLX_MDX  = 28'h0040000,
      ST_RLX_MDXW = 28'h0080000,
      ST_RLX_MDY  = 28'h0100000,
      ST_RLX_MDYW = 28'h0200000,
      ST_RLX_UPD  = 28'h0400000,
      ST_RLX_WRA  = 28'h0800000,
      ST_RLX_WRB  = 28'h1000000,
      ST_EM_RD    = 28'h2000000,
      ST_EM_LD    = 28'h4000000,
      ST_EM_HOLD  = 28'h8000000
   } vrs_state_type;

   vrs_state_type     state_ff, state_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [3:0]        pass_ff, pass_in;

   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(SEGMENTS);
   localparam logic [NODE_W-1:0] LAST_SEG  = NODE_W'(SEGMENTS - 1);

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_EM_HOLD;

   always_comb begin
      state_in = state_ff;
      node_in  = node_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      cmd.node = node_ff;
      cmd.waddr = node_ff;
      cmd.raddr = node_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               node_in     = '0;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = stat.is_step ? ST_GRAV_SQ : ST_INIT_WR;
         end
         ST_INIT_WR: begin
            cmd.we_pos   = 1'b1;
            cmd.we_prev  = 1'b1;
            cmd.wsrc     = WS_INIT;
            cmd.acc_step = 1'b1;
            if (node_ff == LAST_NODE) begin
               node_in  = '0;
               state_in = ST_EM_RD;
            end else begin
               node_in = node_ff + 1'b1;
            end
         end
         ST_GRAV_SQ: begin
            cmd.grav_sq = 1'b1;
            state_in    = ST_GRAV_MUL;
         end
         ST_GRAV_MUL: begin
            cmd.grav_mul = 1'b1;
            state_in     = ST_INT_ANCH;
         end
         ST_INT_ANCH: begin
            cmd.waddr   = '0;
            cmd.we_pos  = 1'b1;
            cmd.we_prev = 1'b1;
            cmd.wsrc    = WS_ANCH;
            node_in     = NODE_W'(1);
            state_in    = ST_INT_RD;
         end
         ST_INT_RD: begin
            state_in = ST_INT_MUL;
         end
         ST_INT_MUL: begin
            cmd.int_mul = 1'b1;
            state_in    = ST_INT_WR;
         end
         ST_INT_WR: begin
            cmd.we_pos  = 1'b1;
            cmd.we_prev = 1'b1;
            cmd.wsrc    = WS_INTEG;
            if (node_ff == LAST_NODE) begin
               node_in  = '0;
               pass_in  = '0;
               state_in = (stat.passes == 4'd0) ? ST_EM_RD : ST_RLX_RDA;
            end else begin
               node_in  = node_ff + 1'b1;
               state_in = ST_INT_RD;
            end
         end
         ST_RLX_RDA: begin
            cmd.raddr = '0;
            state_in  = ST_RLX_LDA;
         end
         ST_RLX_LDA: begin
            cmd.load_a = 1'b1;
            state_in   = ST_RLX_RDB;
         end
         ST_RLX_RDB: begin
            cmd.raddr = node_ff + 1'b1;
            state_in  = ST_RLX_LDB;
         end
         ST_RLX_LDB: begin
            cmd.load_b = 1'b1;
            state_in   = ST_RLX_SQX;
         end
         ST_RLX_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = ST_RLX_SQY;
         end
         ST_RLX_SQY: begin
            cmd.sq_y = 1'b1;
            state_in = ST_RLX_SQS;
         end
         ST_RLX_SQS: begin
            if (stat.skip) begin
               state_in = ST_RLX_WRA;
            end else begin
               cmd.sqrt_start = 1'b1;
               state_in       = ST_RLX_SQW;
            end
         end
         ST_RLX_SQW: begin
            if (stat.sqrt_done) begin
               state_in = ST_RLX_ERR;
            end
         end
         ST_RLX_ERR: begin
            cmd.err_calc  = 1'b1;
            cmd.first_seg = node_ff == '0;
            state_in      = ST_RLX_MDX;
         end
         ST_RLX_MDX: begin
            cmd.md_start = 1'b1;
            state_in     = ST_RLX_MDXW;
         end
         ST_RLX_MDXW: begin
            if (stat.md_done) begin
               cmd.take_c = 1'b1;
               state_in   = ST_RLX_MDY;
            end
         end
         ST_RLX_MDY: begin
            cmd.md_start = 1'b1;
            cmd.md_y     = 1'b1;
            state_in     = ST_RLX_MDYW;
         end
         ST_RLX_MDYW: begin
            cmd.md_y = 1'b1;
            if (stat.md_done) begin
               cmd.take_c = 1'b1;
               state_in   = ST_RLX_UPD;
            end
         end
         ST_RLX_UPD: begin
            cmd.upd       = 1'b1;
            cmd.first_seg = node_ff == '0;
            state_in      = ST_RLX_WRA;
         end
         ST_RLX_WRA: begin
            cmd.we_pos  = 1'b1;
            cmd.wsrc    = WS_A;
            cmd.shift_a = 1'b1;
            if (node_ff == LAST_SEG) begin
               state_in = ST_RLX_WRB;
            end else begin
               node_in  = node_ff + 1'b1;
               state_in = ST_RLX_RDB;
            end
         end
         ST_RLX_WRB: begin
            cmd.waddr  = LAST_NODE;
            cmd.we_pos = 1'b1;
            cmd.wsrc   = WS_A;
            node_in    = '0;
            if ({1'b0, pass_ff} + 5'd1 == {1'b0, stat.passes}) begin
               state_in = ST_EM_RD;
            end else begin
               pass_in  = pass_ff + 4'd1;
               state_in = ST_RLX_RDA;
            end
         end
         ST_EM_RD: begin
            state_in = ST_EM_LD;
         end
         ST_EM_LD: begin
            cmd.em_load = 1'b1;
            state_in    = ST_EM_HOLD;
         end
         ST_EM_HOLD: begin
            if (!rsp_stall) begin
               if (node_ff == LAST_NODE) begin
                  state_in = ST_IDLE;
               end else begin
                  node_in  = node_ff + 1'b1;
                  state_in = ST_EM_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         node_ff  <= '0;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         node_ff  <= node_in;
         pass_ff  <= pass_in;
      end
   end

endmodule

/* rtl/verlet_rope_step_unit.sv */
// Top level of the hanging-rope step unit: sequencer plus datapath.
// Depends on vrs_pkg, vrs_ctrl, vrs_datapath (and below it vrs_ram,
// vrs_isqrt, vrs_muldiv).
//
//   channel | dir | handshake              | payload
//   req     | in  | req_valid / req_stall  | command, pivot_x, pivot_y, time_step
//   rsp     | out | rsp_valid / rsp_stall  | node_index, node_x, node_y, last_node
//   csr     | in  | csr_valid / csr_ready  | csr_index, csr_wdata
//
// One command beat at a time; req_stall is high from acceptance until the
// last node beat has been taken. Init: all nodes are written, then the node
// beats are offered. Step: gravity term, anchor write and integration of each
// node, then one relaxation sweep over the segments per pass; a segment runs
// through the square root and two multiply-divide runs (x, then y), unless it
// is so short that it is skipped. Each node beat is read, loaded into the
// output register and held until taken; rsp_valid drops between beats.
// Reset is synchronous; it clears the sequencer, the node-valid bits (so
// all positions read as zero) and loads the register defaults.
module verlet_rope_step_unit
   import vrs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_command,
   input  logic [31:0]          req_pivot_x,
   input  logic [31:0]          req_pivot_y,
   input  logic [15:0]          req_time_step,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [INDEX_W-1:0]   rsp_node_index,
   output logic [31:0]          rsp_node_x,
   output logic [31:0]          rsp_node_y,
   output logic                 rsp_last_node,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   vrs_cmd_type  cmd;
   vrs_stat_type stat;

   // sequencer: owns both handshakes and the node/pass counters
   vrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: node RAMs, arithmetic units, config and output registers
   vrs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_command    (req_command),
      .req_pivot_x    (req_pivot_x),
      .req_pivot_y    (req_pivot_y),
      .req_time_step  (req_time_step),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_node_index (rsp_node_index),
      .rsp_node_x     (rsp_node_x),
      .rsp_node_y     (rsp_node_y),
      .rsp_last_node  (rsp_last_node)
   );

endmodule

/* test/verlet_rope_step_checker.sv */
// Checker for the rope step unit: watches req, rsp and csr, predicts node beats.
// Depends on vrs_pkg for port widths and register indexes.
module verlet_rope_step_checker
   import vrs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_command,
   input  logic [31:0]          req_pivot_x,
   input  logic [31:0]          req_pivot_y,
   input  logic [15:0]          req_time_step,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [INDEX_W-1:0]   rsp_node_index,
   input  logic [31:0]          rsp_node_x,
   input  logic [31:0]          rsp_node_y,
   input  logic                 rsp_last_node,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output int                   fail_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [INDEX_W-1:0] index;
      logic [31:0]        x;
      logic [31:0]        y;
      logic               last;
   } node_beat_type;

   node_beat_type node_q[$];

   logic signed [31:0] pos_x[NODE_COUNT];
   logic signed [31:0] pos_y[NODE_COUNT];
   logic signed [31:0] old_x[NODE_COUNT];
   logic signed [31:0] old_y[NODE_COUNT];
   logic [30:0] gravity;
   logic [15:0] damping;
   logic [30:0] seg_len;
   logic [3:0]  passes;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -64'sh80000000) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic [63:0] root64(logic [63:0] n);
      logic [63:0] r;
      logic [63:0] t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   // truncated |delta|*|err|/div with the sign of delta*err
   function automatic longint pull(longint delta, longint err, logic [63:0] div);
      logic [127:0] prod;
      logic [63:0]  ad;
      logic [63:0]  ae;
      longint       m;
      ad = delta < 0 ? -delta : delta;
      ae = err < 0 ? -err : err;
      prod = ad * ae;
      prod = prod / div;
      m = prod[63:0];
      return ((delta < 0) != (err < 0)) ? -m : m;
   endfunction

   task automatic relax(int i);
      longint      dx;
      longint      dy;
      longint      err;
      logic [63:0] ax;
      logic [63:0] ay;
      logic [63:0] d2;
      logic [63:0] seg_dist;
      longint      cx;
      longint      cy;
      dx = longint'(pos_x[i+1]) - longint'(pos_x[i]);
      dy = longint'(pos_y[i+1]) - longint'(pos_y[i]);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ax < 64'h80000000 && ay < 64'h80000000) begin
         d2 = ax * ax + ay * ay;
         if (d2 < SHORT_SQ) return;   // too short to have a direction
         seg_dist = root64(d2);
      end else begin
         seg_dist = root64((ax >> 1) * (ax >> 1) + (ay >> 1) * (ay >> 1)) << 1;
      end
      err = longint'(seg_dist) - longint'({33'd0, seg_len});
      if (i != 0) seg_dist = seg_dist << 1;
      cx = pull(dx, err, seg_dist);
      cy = pull(dy, err, seg_dist);
      pos_x[i+1] = clamp32(longint'(pos_x[i+1]) - cx);
      pos_y[i+1] = clamp32(longint'(pos_y[i+1]) - cy);
      if (i != 0) begin
         pos_x[i] = clamp32(longint'(pos_x[i]) + cx);
         pos_y[i] = clamp32(longint'(pos_y[i]) + cy);
      end
   endtask

   task automatic advance_rope(logic cmd, logic signed [31:0] ax, logic signed [31:0] ay,
                               logic [15:0] dt);
      logic [63:0] gterm;
      longint      g;
      longint      vx;
      longint      vy;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      node_beat_type nb;
      if (cmd != CMD_STEP) begin
         for (int i = 0; i < NODE_COUNT; i++) begin
            pos_x[i] = ax;
            pos_y[i] = clamp32(longint'(ay) + longint'(i) * longint'({33'd0, seg_len}));
            old_x[i] = pos_x[i];
            old_y[i] = pos_y[i];
         end
      end else begin
         gterm = {33'd0, gravity} * ({48'd0, dt} * {48'd0, dt});
         g = longint'((gterm + 64'h80000000) >> 32);
         pos_x[0] = ax; old_x[0] = ax;
         pos_y[0] = ay; old_y[0] = ay;
         for (int i = 1; i < NODE_COUNT; i++) begin
            // damped velocity, rounded half up (arithmetic shift floors)
            vx = ((longint'(pos_x[i]) - longint'(old_x[i])) * longint'({48'd0, damping})
                  + 32768) >>> 16;
            vy = ((longint'(pos_y[i]) - longint'(old_y[i])) * longint'({48'd0, damping})
                  + 32768) >>> 16;
            nx = clamp32(longint'(pos_x[i]) + vx);
            ny = clamp32(longint'(pos_y[i]) + vy + g);
            old_x[i] = pos_x[i];
            old_y[i] = pos_y[i];
            pos_x[i] = nx;
            pos_y[i] = ny;
         end
         for (int p = 0; p < passes; p++)
            for (int i = 0; i < SEGMENTS; i++) relax(i);
      end
      for (int i = 0; i < NODE_COUNT; i++) begin
         nb.index = INDEX_W'(i);
         nb.x = pos_x[i];
         nb.y = pos_y[i];
         nb.last = (i == SEGMENTS);
         node_q.push_back(nb);
      end
   endtask

   always @(posedge clock) begin
      node_beat_type want;
      if (reset) begin
         for (int i = 0; i < NODE_COUNT; i++) begin
            pos_x[i] = 0; pos_y[i] = 0; old_x[i] = 0; old_y[i] = 0;
         end
         gravity = GRAVITY_RST;
         damping = DAMPING_RST;
         seg_len = SEGLEN_RST;
         passes = PASSES_RST;
         node_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRAVITY: gravity = csr_wdata[30:0];
               CSR_DAMPING: damping = csr_wdata[15:0];
               CSR_SEGLEN:  seg_len = csr_wdata[30:0];
               CSR_PASSES:  passes = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            advance_rope(req_command, req_pivot_x, req_pivot_y, req_time_step);
         if (rsp_valid && !rsp_stall) begin
            if (node_q.size() == 0) begin
               report("unexpected node beat", {26'd0, rsp_node_index}, 0);
            end else begin
               want = node_q.pop_front();
               if (rsp_node_index != want.index)
                  report("node_index", {26'd0, rsp_node_index}, {26'd0, want.index});
               if (rsp_node_x != want.x) report("node_x", rsp_node_x, want.x);
               if (rsp_node_y != want.y) report("node_y", rsp_node_y, want.y);
               if (rsp_last_node != want.last)
                  report("last_node", {31'd0, rsp_last_node}, {31'd0, want.last});
            end
         end
      end
      pending = node_q.size();
   end

endmodule

/* test/verlet_rope_step_unit_test.sv */
// Top of the rope step unit bench: clock, reset, command and csr stimulus.
// Depends on vrs_pkg, verlet_rope_step_unit and verlet_rope_step_checker.
module verlet_rope_step_unit_test
   import vrs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 200000;   // well above the run of a 15-pass step
   localparam int HOLD_CYCLES = 400;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_stall;
   logic                 req_command = 0;
   logic [31:0]          req_pivot_x = 0;
   logic [31:0]          req_pivot_y = 0;
   logic [15:0]          req_time_step = 0;
   logic                 rsp_valid;
   logic                 rsp_stall = 0;
   logic [INDEX_W-1:0]   rsp_node_index;
   logic [31:0]          rsp_node_x;
   logic [31:0]          rsp_node_y;
   logic                 rsp_last_node;
   logic                 csr_valid = 0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GRAVITY;
   logic [31:0]          csr_wdata = 0;

   int fail_count;
   int pending;
   bit quiet = 0;      // no idling on either side
   bit hold_rsp = 0;   // ask the receiver for one long hold-off
   int idle_cycles = 0;
   logic [31:0] walk_x;
   logic [31:0] walk_y;

   always #4 clock = ~clock;

   verlet_rope_step_unit dut (.*);

   verlet_rope_step_checker chk (.*);

   // receiver: random stall, plus one long hold once node beats are offered
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            while (!rsp_valid) @(posedge clock);
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 0;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 24);
         end
      end
   end

   // watchdog: cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[verlet_rope_step_unit] ERROR");
         $finish;
      end
   end

   // one command beat; valid stays up into the next beat unless we idle
   task automatic send(logic cmd, logic [31:0] ax, logic [31:0] ay, logic [15:0] dt);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_pivot_x <= ax;
      req_pivot_y <= ay;
      req_time_step <= dt;
      do @(posedge clock); while (req_stall);
      if (!quiet && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // one edge first so the checker has queued the last accepted command
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(logic [31:0] g, logic [31:0] d, logic [31:0] l, logic [31:0] p);
      drain();
      csr_write(CSR_GRAVITY, g);
      csr_write(CSR_DAMPING, d);
      csr_write(CSR_SEGLEN, l);
      csr_write(CSR_PASSES, p);
   endtask

   // mostly a swinging rope near a drifting anchor, some raw noise
   task automatic random_item();
      int r;
      r = $urandom_range(99);
      if (r < 8) begin
         send(1'($urandom_range(1)), $urandom, $urandom, 16'($urandom));
      end else if (r < 15) begin
         walk_x = $urandom_range(2000) << 16;
         walk_y = $urandom_range(2000) << 16;
         send(1'b0, walk_x, walk_y, 16'($urandom));
      end else begin
         walk_x = walk_x + ($urandom_range(8191) - 4096) * 64;
         walk_y = walk_y + ($urandom_range(8191) - 4096) * 64;
         send(CMD_STEP, walk_x, walk_y,
              ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(300, 3000)));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, default registers: rest, gravity extremes, saturating anchors
      send(1'b0, 32'd0, 32'd0, 16'hFFFF);
      send(CMD_STEP, 32'd0, 32'd0, 16'd1092);
      send(CMD_STEP, 32'd0, 32'd0, 16'd0);
      send(CMD_STEP, 32'd0, 32'd0, 16'hFFFF);
      send(1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'd0);
      send(CMD_STEP, 32'h80000000, 32'h80000000, 16'hFFFF);
      send(1'b0, 32'h80000000, 32'h80000000, 16'd0);
      send(CMD_STEP, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'd1000);
      send(CMD_STEP, 32'h12345678, 32'hEDCBA987, 16'h5555);

      // zero passes, no gravity, no damping, zero rest length
      set_regs(0, 0, 0, 0);
      send(1'b0, 32'd5, 32'd7, 16'd0);
      send(CMD_STEP, 32'h00010000, 32'd7, 16'hFFFF);
      send(CMD_STEP, 32'hFFFF0000, 32'd7, 16'hFFFF);

      // every node coincident: short segments are skipped
      set_regs(0, 0, 0, 2);
      send(1'b0, 32'h00400000, 32'h00400000, 16'd0);
      send(CMD_STEP, 32'h00400000, 32'h00400000, 16'd0);
      send(CMD_STEP, 32'h00400003, 32'h00400002, 16'd0);

      // register maxima, with a single pass
      set_regs(32'h7FFFFFFF, 32'hFFFF, 32'h7FFFFFFF, 1);
      send(1'b0, 32'd0, 32'h80000000, 16'd0);
      send(CMD_STEP, 32'd0, 32'h80000000, 16'hFFFF);
      send(CMD_STEP, 32'h7FFFFFFF, 32'd0, 16'd300);

      // the most passes, few items since each step is slow
      set_regs(32'(GRAVITY_RST), 32'(DAMPING_RST), 32'(SEGLEN_RST), 15);
      send(1'b0, 32'h01000000, 32'h01000000, 16'd0);
      send(CMD_STEP, 32'h01100000, 32'h01000000, 16'd1092);
      send(CMD_STEP, 32'h01200000, 32'h00F00000, 16'd2000);

      // random phases with varied settings
      for (int ph = 0; ph < 8; ph++) begin
         set_regs($urandom_range(0, 80000000), $urandom_range(50000, 65535),
                  (ph == 2) ? 32'($urandom) : $urandom_range(1 << 16, 40 << 16),
                  $urandom_range(1, 3));
         quiet = (ph == 4);
         walk_x = $urandom_range(1000) << 16;
         walk_y = $urandom_range(1000) << 16;
         send(1'b0, walk_x, walk_y, 16'd0);
         for (int n = 0; n < 34; n++) begin
            if (ph == 1 && n == 10) hold_rsp = 1;   // back-pressure while offering
            if (ph == 3 && n == 17) drain();        // sender waits for every beat
            random_item();
         end
      end
      quiet = 0;

      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("[verlet_rope_step_unit] OK");
      else
         $display("[verlet_rope_step_unit] ERROR");
      $finish;
   end

endmodule
